[sv/srpl_pkg.sv]
// shared types and codes for the sorted range predecessor lookup block
`timescale 1ns / 1ps
package srpl_pkg;
  typedef logic [1:0] op_t;
  localparam op_t OP_CLEAR  = 2'd0;
  localparam op_t OP_INSERT = 2'd1;
  localparam op_t OP_LOOKUP = 2'd2;
  localparam op_t OP_NONE   = 2'd3;

  typedef logic [2:0] status_t;
  localparam status_t ST_INSERTED = 3'd0;
  localparam status_t ST_CLEARED  = 3'd1;
  localparam status_t ST_FOUND    = 3'd2;
  localparam status_t ST_BELOW    = 3'd3;
  localparam status_t ST_EMPTY    = 3'd4;
  localparam status_t ST_FULL     = 3'd5;

  localparam int RANK_BITS = 6;
  localparam int OP_BITS   = 2;
  localparam int ST_BITS   = 3;

  // handshake between queue and back end
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;
endpackage

[sv/srpl_front.sv]
// front end: takes requests, splits fields and drops unused modes
`timescale 1ns / 1ps
module srpl_front #(
  parameter int KEY_BITS = 48,
  parameter int TAG_BITS = 32,
  parameter int IN_W     = 88
) (
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,
  input  logic                 q_ready,
  output logic                 q_push,
  output srpl_pkg::op_t        q_op,
  output logic [KEY_BITS-1:0]  q_key,
  output logic [TAG_BITS-1:0]  q_tag
);
  import srpl_pkg::*;

  assign in_tready = q_ready;
  assign q_op  = in_tdata[OP_BITS-1:0];
  assign q_key = in_tdata[OP_BITS +: KEY_BITS];
  assign q_tag = in_tdata[OP_BITS+KEY_BITS +: TAG_BITS];
  // unused mode is consumed with no result
  assign q_push = in_tvalid && q_ready && (q_op != OP_NONE);
endmodule

[sv/srpl_fifo.sv]
// two-entry request queue between front and back end
`timescale 1ns / 1ps
module srpl_fifo #(
  parameter int W = 82
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [W-1:0]  push_data,
  output logic          push_ready,
  output srpl_pkg::hs_t pop_hs_o,
  input  logic          pop_ready,
  output logic [W-1:0]  pop_data
);
  import srpl_pkg::*;

  logic [W-1:0] mem_r [2];
  logic         wptr_r, wptr_nxt;
  logic         rptr_r, rptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         pop;

  assign push_ready     = (cnt_r != 2'd2);
  assign pop_hs_o.valid = (cnt_r != 2'd0);
  assign pop_hs_o.ready = pop_ready;
  assign pop_data       = mem_r[rptr_r];
  assign pop            = pop_hs_o.valid && pop_ready;

  always_comb begin
    wptr_nxt = wptr_r ^ push;
    rptr_nxt = rptr_r ^ pop;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end
endmodule

[sv/srpl_back.sv]
// back end: sorted cell row with compare, shift insert and predecessor select
`timescale 1ns / 1ps
module srpl_back #(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 48,
  parameter int TAG_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  srpl_pkg::hs_t                   q_hs,
  output logic                            q_pop,
  input  srpl_pkg::op_t                   q_op,
  input  logic [KEY_BITS-1:0]             q_key,
  input  logic [TAG_BITS-1:0]             q_tag,
  output logic                            res_valid,
  input  logic                            res_ready,
  output srpl_pkg::status_t               res_status,
  output logic [TAG_BITS-1:0]             res_tag,
  output logic [srpl_pkg::RANK_BITS-1:0]  res_rank
);
  import srpl_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]          state_r, state_nxt;
  op_t                 op_r;
  logic [KEY_BITS-1:0] key_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [DEPTH-1:0]    le_r;
  logic [KEY_BITS-1:0] cell_key_r [DEPTH];
  logic [TAG_BITS-1:0] cell_tag_r [DEPTH];
  logic                res_valid_r, res_valid_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [TAG_BITS-1:0] res_tag_r, res_tag_nxt;
  logic [RANK_BITS-1:0] res_rank_r, res_rank_nxt;
  logic                exec_go;
  logic                full, empty;
  logic [TAG_BITS-1:0] sel_tag;
  logic [IW-1:0]       sel_idx;
  logic [IW+RANK_BITS-1:0] idx_ext;

  assign q_pop      = (state_r == S_IDLE) && q_hs.valid;
  assign exec_go    = (state_r == S_EXEC) && (!res_valid_r || res_ready);
  assign full       = (cnt_r == CW'(DEPTH));
  assign empty      = (cnt_r == '0);
  assign res_valid  = res_valid_r;
  assign res_status = res_status_r;
  assign res_tag    = res_tag_r;
  assign res_rank   = res_rank_r;

  // last cell whose key is not above the query; le is a run of ones from cell 0
  always_comb begin
    sel_tag = '0;
    sel_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (le_r[i] && ((i == DEPTH - 1) || !le_r[(i + 1) % DEPTH])) begin
        sel_tag = sel_tag | cell_tag_r[i];
        sel_idx = sel_idx | IW'(i);
      end
    end
    idx_ext = {{RANK_BITS{1'b0}}, sel_idx};
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    res_valid_nxt  = res_valid_r && !res_ready;
    res_status_nxt = res_status_r;
    res_tag_nxt    = res_tag_r;
    res_rank_nxt   = res_rank_r;
    unique case (state_r)
      S_IDLE: if (q_pop) state_nxt = S_CMP;
      S_CMP:  state_nxt = S_EXEC;
      S_EXEC: begin
        if (exec_go) begin
          state_nxt     = S_IDLE;
          res_valid_nxt = 1'b1;
          res_tag_nxt   = '0;
          res_rank_nxt  = '0;
          unique case (op_r)
            OP_CLEAR: begin
              cnt_nxt        = '0;
              res_status_nxt = ST_CLEARED;
            end
            OP_INSERT: begin
              if (full) begin
                res_status_nxt = ST_FULL;
              end else begin
                cnt_nxt        = cnt_r + CW'(1);
                res_status_nxt = ST_INSERTED;
              end
            end
            default: begin
              if (empty) begin
                res_status_nxt = ST_EMPTY;
              end else if (!le_r[0]) begin
                res_status_nxt = ST_BELOW;
                res_tag_nxt    = cell_tag_r[0];
              end else begin
                res_status_nxt = ST_FOUND;
                res_tag_nxt    = sel_tag;
                res_rank_nxt   = idx_ext[RANK_BITS-1:0];
              end
            end
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_tag_r    <= res_tag_nxt;
    res_rank_r   <= res_rank_nxt;
    if (q_pop) begin
      op_r  <= q_op;
      key_r <= q_key;
      tag_r <= q_tag;
    end
    if (state_r == S_CMP) begin
      for (int i = 0; i < DEPTH; i++) begin
        le_r[i] <= (CW'(i) < cnt_r) && (cell_key_r[i] <= key_r);
      end
    end
  end

  // cells above the insert point move up one place
  always_ff @(posedge clk) begin
    if (exec_go && (op_r == OP_INSERT) && !full) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (!le_r[i]) begin
          if ((i == 0) || le_r[(i + DEPTH - 1) % DEPTH]) begin
            cell_key_r[i] <= key_r;
            cell_tag_r[i] <= tag_r;
          end else begin
            cell_key_r[i] <= cell_key_r[(i + DEPTH - 1) % DEPTH];
            cell_tag_r[i] <= cell_tag_r[(i + DEPTH - 1) % DEPTH];
          end
        end
      end
    end
  end
endmodule

[sv/sorted_range_predecessor_lookup_core.sv]
// Sorted range predecessor lookup: keeps a sorted table of key/tag entries.
// in_* channel carries requests: clear, insert (key, tag) or lookup (key).
// out_* channel returns one result per request: status, found tag, rank.
// A lookup returns the entry with the greatest key not above the query;
// among equal keys the one inserted last wins. A query below every key
// returns the smallest entry flagged as below; an empty table is flagged,
// an insert into a full table is dropped and flagged. Mode 3 is consumed
// with no result.
// Requests enter a two-entry queue so the input keeps flowing while the
// back end works. The back end handles one request at a time, in order:
// pop, parallel compare over every cell, then shift insert or predecessor
// select, with a compare register in front of the select.
// A result waits in the output register while out_tready is low; the back
// end then holds its finished request and the queue fills, lowering
// in_tready. Reset empties the table, the queue and the output register.
`timescale 1ns / 1ps
module sorted_range_predecessor_lookup_core #(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 48,
  parameter int TAG_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // mode, key, tag from bit 0 up, zero padded
  input  logic [((2 + KEY_BITS + TAG_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // status, found_tag, rank from bit 0 up, zero padded
  output logic [((3 + TAG_BITS + 6 + 7) / 8) * 8 - 1:0] out_tdata
);
  import srpl_pkg::*;

  localparam int IN_W  = ((2 + KEY_BITS + TAG_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((3 + TAG_BITS + 6 + 7) / 8) * 8;
  localparam int QW    = OP_BITS + KEY_BITS + TAG_BITS;

  logic                 q_push, q_ready, q_pop;
  op_t                  f_op;
  logic [KEY_BITS-1:0]  f_key;
  logic [TAG_BITS-1:0]  f_tag;
  logic [QW-1:0]        q_out;
  hs_t                  q_hs;
  status_t              r_status;
  logic [TAG_BITS-1:0]  r_tag;
  logic [RANK_BITS-1:0] r_rank;

  srpl_front #(.KEY_BITS(KEY_BITS), .TAG_BITS(TAG_BITS), .IN_W(IN_W)) u_front (
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .q_ready(q_ready), .q_push(q_push), .q_op(f_op), .q_key(f_key), .q_tag(f_tag)
  );

  srpl_fifo #(.W(QW)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data({f_tag, f_key, f_op}),
    .push_ready(q_ready), .pop_hs_o(q_hs), .pop_ready(q_pop), .pop_data(q_out)
  );

  srpl_back #(.DEPTH(DEPTH), .KEY_BITS(KEY_BITS), .TAG_BITS(TAG_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_hs(q_hs), .q_pop(q_pop),
    .q_op(q_out[OP_BITS-1:0]), .q_key(q_out[OP_BITS +: KEY_BITS]),
    .q_tag(q_out[OP_BITS+KEY_BITS +: TAG_BITS]),
    .res_valid(out_tvalid), .res_ready(out_tready),
    .res_status(r_status), .res_tag(r_tag), .res_rank(r_rank)
  );

  assign out_tdata = OUT_W'({r_rank, r_tag, r_status});

`ifndef ASSERT_OFF
  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (in_tvalid && in_tready))
    else $error("queue written without an accepted request");

  a_unused_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tdata[OP_BITS-1:0] == OP_NONE)) |-> !q_push)
    else $error("unused mode entered the queue");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (r_status <= ST_FULL))
    else $error("illegal status code");
`endif
endmodule

[tb/srpl_checker.sv]
// checker for the sorted range predecessor lookup: predicts results and compares them
`timescale 1ns / 1ps
module srpl_checker #(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 48,
  parameter int TAG_BITS = 32,
  parameter int IW       = 88,
  parameter int OW       = 48
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_tready,
  input  logic [IW-1:0] in_tdata,
  input  logic          out_tvalid,
  input  logic          out_tready,
  input  logic [OW-1:0] out_tdata,
  output int            fail_count,
  output int            pending
);
  import srpl_pkg::*;

  typedef struct packed {
    status_t             status;
    logic [TAG_BITS-1:0] tag;
    logic [5:0]          rank;
  } lookup_res_t;

  logic [KEY_BITS-1:0] tbl_keys[DEPTH];
  logic [TAG_BITS-1:0] tbl_tags[DEPTH];
  int                  n_entries;
  lookup_res_t         expected_q[$];

  // number of cells with key not above k
  function automatic int rank_of(logic [KEY_BITS-1:0] k);
    int n;
    n = 0;
    for (int i = 0; i < n_entries; i++) if (tbl_keys[i] <= k) n = i + 1;
    return n;
  endfunction

  task automatic apply_request(logic [IW-1:0] d);
    op_t                 op;
    logic [KEY_BITS-1:0] k;
    logic [TAG_BITS-1:0] t;
    lookup_res_t         r;
    int                  p;
    op = d[1:0];
    k  = d[2 +: KEY_BITS];
    t  = d[2 + KEY_BITS +: TAG_BITS];
    r  = '0;
    case (op)
      OP_CLEAR: begin
        n_entries = 0;
        r.status = ST_CLEARED;
      end
      OP_INSERT: begin
        if (n_entries >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          p = rank_of(k);
          for (int i = n_entries; i > p; i--) begin
            tbl_keys[i] = tbl_keys[i-1];
            tbl_tags[i] = tbl_tags[i-1];
          end
          tbl_keys[p] = k;
          tbl_tags[p] = t;
          n_entries++;
          r.status = ST_INSERTED;
        end
      end
      OP_LOOKUP: begin
        if (n_entries == 0) begin
          r.status = ST_EMPTY;
        end else begin
          p = rank_of(k);
          if (p == 0) begin
            r.status = ST_BELOW;
            r.tag = tbl_tags[0];
          end else begin
            r.status = ST_FOUND;
            r.tag = tbl_tags[p-1];
            r.rank = 6'(p - 1);
          end
        end
      end
      default: return;
    endcase
    expected_q.push_back(r);
  endtask

  always @(posedge clk) begin
    lookup_res_t got, exp_r;
    if (!rst_n) begin
      n_entries  <= 0;
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (in_tvalid && in_tready) apply_request(in_tdata);
      if (out_tvalid && out_tready) begin
        got.status = out_tdata[2:0];
        got.tag    = out_tdata[3 +: TAG_BITS];
        got.rank   = out_tdata[3 + TAG_BITS +: 6];
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got.status !== exp_r.status || got.tag !== exp_r.tag ||
              got.rank !== exp_r.rank) begin
            $display("%0t: mismatch, expected st=%0d tag=%h rank=%0d, %s st=%0d tag=%h rank=%0d",
                     $realtime, exp_r.status, exp_r.tag, exp_r.rank, "actual",
                     got.status, got.tag, got.rank);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending = expected_q.size();
  end
endmodule

[tb/sorted_range_predecessor_lookup_core_tb.sv]
// stimulus and verdict for the sorted range predecessor lookup block
`timescale 1ns / 1ps
module sorted_range_predecessor_lookup_core_tb;
  import srpl_pkg::*;
  localparam int DEPTH = 64, KB = 48, TB = 32;
  localparam int IW = ((2 + KB + TB + 7) / 8) * 8;
  localparam int OW = ((3 + TB + 6 + 7) / 8) * 8;

  logic          clk = 0;
  logic          rst_n = 0;
  logic          in_tvalid = 0;
  logic          in_tready;
  logic [IW-1:0] in_tdata = '0;
  logic          out_tvalid;
  logic          out_tready = 0;
  logic [OW-1:0] out_tdata;
  int            fail_count, pending;
  logic          hold_off = 0;
  logic [KB-1:0] key_pool[16];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  sorted_range_predecessor_lookup_core #(.DEPTH(DEPTH), .KEY_BITS(KB), .TAG_BITS(TB)) u_top (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata));

  srpl_checker #(.DEPTH(DEPTH), .KEY_BITS(KB), .TAG_BITS(TB), .IW(IW), .OW(OW)) u_chk (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .fail_count(fail_count), .pending(pending));

  // receiver stall pattern, with stall-free stretches and held-off windows
  always @(posedge clk) begin
    int ph;
    ph = int'($realtime / 10);
    if (hold_off) out_tready <= 0;
    else if ((ph / 400) % 3 == 0) out_tready <= 1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  // random key: extremes, reused keys for ties, or fully random
  function automatic logic [KB-1:0] pick_key();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return key_pool[$urandom_range(0, 15)];
      default: return KB'({$urandom(), $urandom()});
    endcase
  endfunction

  task automatic send(op_t op, logic [KB-1:0] k, logic [TB-1:0] t);
    logic [IW-1:0] d;
    d = '0;
    d[1:0] = op;
    d[2 +: KB] = k;
    d[2 + KB +: TB] = t;
    in_tvalid <= 1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic idle_gap();
    in_tvalid <= 0;
    repeat ($urandom_range(1, 4)) @(posedge clk);
  endtask

  initial begin
    int burst, guard, sel;
    logic [KB-1:0] k;
    for (int i = 0; i < 16; i++) key_pool[i] = KB'({$urandom(), $urandom()});
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed
    send(OP_LOOKUP, '0, '0);
    send(OP_NONE, '1, '1);
    send(OP_INSERT, 48'd1000, 32'hffffffff);
    send(OP_LOOKUP, 48'd5, '0);
    send(OP_LOOKUP, 48'd1000, '0);
    send(OP_INSERT, 48'd1000, 32'h12345678);
    send(OP_LOOKUP, 48'd2000, '0);
    send(OP_INSERT, '0, '0);
    send(OP_INSERT, '1, 32'haaaa5555);
    send(OP_LOOKUP, '1, '1);
    send(OP_LOOKUP, '0, '0);
    send(OP_LOOKUP, 48'd999, '0);
    send(OP_CLEAR, '1, '1);
    send(OP_LOOKUP, 48'd1000, '0);
    for (int i = 0; i < DEPTH; i++) send(OP_INSERT, KB'({$urandom(), $urandom()}), $urandom());
    send(OP_INSERT, 48'd7, 32'h5555aaaa);
    send(OP_LOOKUP, '1, '0);
    send(OP_CLEAR, '0, '0);
    // long hold-off while the sender keeps offering requests
    hold_off <= 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off <= 0;
      end
      for (int i = 0; i < 20; i++) send(OP_INSERT, pick_key(), $urandom());
    join
    // random bursts
    for (int n = 0; n < 800; ) begin
      burst = $urandom_range(1, 30);
      for (int b = 0; b < burst; b++) begin
        sel = $urandom_range(0, 99);
        k = pick_key();
        if (sel < 2) send(OP_CLEAR, k, $urandom());
        else if (sel < 4) send(OP_NONE, k, $urandom());
        else if (sel < 50) send(OP_INSERT, k, $urandom());
        else send(OP_LOOKUP, ($urandom_range(0, 1) ? k : k + KB'(1)), $urandom());
        if (sel >= 2 && sel < 4) continue;
        n++;
      end
      if ($urandom_range(0, 2) != 0) idle_gap();
    end
    in_tvalid <= 0;
    guard = 0;
    while (pending != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end
endmodule
